// ----- hw/rtl/ordered_list_engine_macros.svh -----
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define OLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_list_engine: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define OLE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_list_engine: assertion failed");

`else

`define OLE_ASSERT_IMP(label, ante, cons)
`define OLE_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hw/rtl/ole_pkg.sv -----
// shared types and constants for the ordered list engine
package ole_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int WORD_BITS_DEF = 32;

  localparam int OPER_BITS  = 2;
  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 6;
  localparam int ELEM_BITS  = 32;
  localparam int POS_BITS   = 5;
  localparam int STAT_BITS  = 2;

  typedef logic [OPER_BITS-1:0] oper_t;
  typedef logic [STAT_BITS-1:0] stat_t;

  localparam oper_t OP_PUSH_FRONT = 2'd0;
  localparam oper_t OP_PUSH_BACK  = 2'd1;
  localparam oper_t OP_REMOVE     = 2'd2;

  localparam stat_t ST_DONE      = 2'd0;
  localparam stat_t ST_FULL      = 2'd1;
  localparam stat_t ST_BAD_INDEX = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } ole_state_t;

  // tag of a read in flight, lines up with the ram read data
  typedef struct packed {
    logic                valid;
    logic                empty;
    logic [POS_BITS-1:0] position;
    logic                last;
    stat_t               status;
  } ole_arr_t;

  // one result held in the output buffer
  typedef struct packed {
    logic [ELEM_BITS-1:0] element;
    logic [POS_BITS-1:0]  position;
    logic                 last;
    logic                 empty_res;
    stat_t                status;
  } ole_res_t;

endpackage

// ----- hw/rtl/ole_if.sv -----
// request and result channel interfaces

interface ole_in_if;
  import ole_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OPER_BITS-1:0]  operation;
  logic [VALUE_BITS-1:0] value;
  logic [INDEX_BITS-1:0] index;

  modport source (output valid, operation, value, index, input ready);
  modport sink   (input valid, operation, value, index, output ready);
endinterface

interface ole_out_if;
  import ole_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] element;
  logic [POS_BITS-1:0]  position;
  logic                 last;
  logic                 empty_res;
  logic [STAT_BITS-1:0] status;

  modport source (output valid, element, position, last, empty_res, status, input ready);
  modport sink   (input valid, element, position, last, empty_res, status, output ready);
endinterface

// ----- hw/rtl/ole_ram.sv -----
// generic single-port-write ram with registered read
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- hw/rtl/ole_ofifo.sv -----
// two-entry result buffer with read credit for the sequencer
module ole_ofifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ole_pkg::ole_arr_t             arr,
  input  logic [ole_pkg::ELEM_BITS-1:0] rdata,
  output logic                          can_issue,
  ole_out_if.source                     out_ch
);
  import ole_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  ole_res_t   ent0_r, ent0_nxt;
  ole_res_t   ent1_r, ent1_nxt;
  ole_res_t   new_ent;
  logic       push, pop;

  assign push = arr.valid;
  assign pop  = (cnt_r != 2'd0) && out_ch.ready;

  // room for one more read once the one in flight lands
  assign can_issue = pop || (({1'b0, cnt_r} + {2'b00, arr.valid}) < 3'd2);

  always_comb begin
    new_ent.element   = arr.empty ? '0 : rdata;
    new_ent.position  = arr.position;
    new_ent.last      = arr.last;
    new_ent.empty_res = arr.empty;
    new_ent.status    = arr.status;
  end

  always_comb begin
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      ent0_nxt = ent1_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        ent0_nxt = new_ent;
      end else begin
        ent1_nxt = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.element   = ent0_r.element;
  assign out_ch.position  = ent0_r.position;
  assign out_ch.last      = ent0_r.last;
  assign out_ch.empty_res = ent0_r.empty_res;
  assign out_ch.status    = ent0_r.status;
endmodule

// ----- hw/rtl/ole_seq.sv -----
// request sequencer: list update, dump reads and tail compaction write-back
module ole_seq #(
  parameter int CAPACITY  = ole_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = ole_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ole_in_if.sink                      in_ch,
  input  logic                        can_issue,
  output ole_pkg::ole_arr_t           arr,
  output logic                        rd_issue,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [WORD_BITS-1:0]        ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [WORD_BITS-1:0]        ram_rdata
);
  import ole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int IW = INDEX_BITS + 1;

  ole_state_t      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            rm_r, rm_nxt;
  logic [CW-1:0]   rm_idx_r, rm_idx_nxt;
  stat_t           status_r, status_nxt;
  ole_arr_t        arr_r, arr_nxt;
  logic            wb_r, wb_nxt;
  logic [AW-1:0]   wb_addr_r, wb_addr_nxt;

  logic            accept;
  logic            full;
  logic            last_k;
  logic            skip;
  logic [CW-1:0]   src_k;
  logic [AW-1:0]   head_dec;

  // physical slot of logical position j in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] j);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(j);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return AW'(s);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && !arr_r.valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(CAPACITY));
  assign last_k      = (k_r == count_r - CW'(1));
  assign head_dec    = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  // past the removed slot, read one further up
  assign skip        = rm_r && (k_r >= rm_idx_r);
  assign src_k       = k_r + CW'(skip);
  assign arr         = arr_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (can_issue && (count_r == '0 || last_k)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    rm_nxt      = rm_r;
    rm_idx_nxt  = rm_idx_r;
    status_nxt  = status_r;
    arr_nxt     = '0;
    wb_nxt      = 1'b0;
    wb_addr_nxt = wb_addr_r;
    rd_issue    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wb_addr_r;
    ram_wdata   = WORD_BITS'(in_ch.value);
    ram_raddr   = phys(head_r, src_k);

    if (accept) begin
      status_nxt = ST_DONE;
      rm_nxt     = 1'b0;
      k_nxt      = '0;
      case (in_ch.operation)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = phys(head_r, count_r);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE: begin
          if ({1'b0, in_ch.index} >= IW'(count_r)) begin
            status_nxt = ST_BAD_INDEX;
          end else begin
            rm_nxt     = 1'b1;
            rm_idx_nxt = CW'(in_ch.index);
            count_nxt  = count_r - CW'(1);
          end
        end
        default: ;
      endcase
    end

    // word read for the dump lands one slot lower when compacting
    if (wb_r) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_r;
      ram_wdata = ram_rdata;
    end

    if (state_r == S_DUMP && can_issue) begin
      arr_nxt.valid  = 1'b1;
      arr_nxt.status = status_r;
      if (count_r == '0) begin
        arr_nxt.empty = 1'b1;
        arr_nxt.last  = 1'b1;
      end else begin
        rd_issue         = 1'b1;
        arr_nxt.position = POS_BITS'(k_r);
        arr_nxt.last     = last_k;
        wb_nxt           = skip;
        wb_addr_nxt      = phys(head_r, k_r);
        k_nxt            = k_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      k_r      <= '0;
      rm_r     <= 1'b0;
      arr_r    <= '0;
      wb_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      rm_r     <= rm_nxt;
      arr_r    <= arr_nxt;
      wb_r     <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rm_idx_r  <= rm_idx_nxt;
    status_r  <= status_nxt;
    wb_addr_r <= wb_addr_nxt;
  end
endmodule

// ----- hw/rtl/ordered_list_engine.sv -----
// ordered list engine top level
// The list sits in one ram used as a circular buffer with a head pointer, so a push at
// either end is a single write in the cycle the request is accepted. Every request then
// dumps the whole list front to back, one ram read per cycle while the result buffer
// grants read credit; a removal compacts the tail in the same pass by writing each word
// read from above the removed slot back one slot lower. A request is accepted, then each
// element is read in turn through the single ram read port, and the last read returns
// from the registered ram output. The list memory needs no clearing after reset. Up to
// two results are buffered, so the next request can be taken while results still wait
// at the output.
module ordered_list_engine #(
  parameter int CAPACITY  = ole_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = ole_pkg::WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ole_in_if.sink    in_ch,
  ole_out_if.source out_ch
);
  import ole_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  ole_arr_t             arr;
  logic                 can_issue;
  logic                 rd_issue;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [ELEM_BITS-1:0] rdata_elem;

  assign rdata_elem = ELEM_BITS'(ram_rdata);

  ole_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ole_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .can_issue (can_issue),
    .arr       (arr),
    .rd_issue  (rd_issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ole_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .arr       (arr),
    .rdata     (rdata_elem),
    .can_issue (can_issue),
    .out_ch    (out_ch)
  );

`include "ordered_list_engine_macros.svh"

  // compaction write-back never hits the slot being read
  `OLE_ASSERT_IMP(a_no_rw_clash, ram_we && rd_issue, ram_waddr != ram_raddr)
  // no read tag is valid straight after an accepted request
  `OLE_ASSERT_NXT(a_accept_gap, in_ch.valid && in_ch.ready, !arr.valid)
  // an empty-list result is the whole dump
  `OLE_ASSERT_IMP(a_empty_last, arr.valid && arr.empty, arr.last && arr.position == '0)
  `OLE_ASSERT_IMP(a_out_empty, out_ch.valid && out_ch.empty_res, out_ch.last && out_ch.element == '0)

endmodule
